### rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the bounded identifier set unit.
// ----------------------------------------------------------------------------
package bis_pkg;

    // fixed field widths of the request and result transfers
    localparam int ID_IN_W     = 16;
    localparam int INDEX_W     = 6;
    localparam int SIZE_W      = 7;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // request operation, carried on tuser
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RDWAIT,
        ST_OUT
    } t_state;

    // result item, status in the lowest bit
    typedef struct packed {
        logic              empty_res;
        logic [SIZE_W-1:0] size;
        logic [ID_IN_W-1:0] read_id;
        logic              found;
        logic              status;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

### rtl/bounded_id_set_unit.sv
// ----------------------------------------------------------------------------
// bounded_id_set_unit
// Set of up to CAPACITY nonzero identifiers kept in contiguous memory slots.
// ----------------------------------------------------------------------------
// The set lives in one single-port-read memory of CAPACITY entries plus a
// member count; one request is taken at a time. Add, remove and lookup scan
// the occupied slots one per cycle through the memory read port; a scan ends
// at a hit or after the last occupied slot. A remove that hits at slot p then
// moves the later entries down one per cycle. Add of zero or to a full set,
// remove or lookup of zero, and a read past the count skip the scan and go
// straight to the output state; a valid read first waits for the memory read.
// Slots past the count are never read, so there is no clearing pass after
// reset. A finished result waits in the output register while the next
// request is already accepted.
module bounded_id_set_unit #(
    parameter int CAPACITY = 64,
    parameter int ID_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request: tdata = id [15:0], index [21:16]; tuser = operation [1:0]
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bis_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]                      s_axis_tuser,
    // result: tdata = status [0], found [1], read_id [17:2], size [24:18],
    //         empty_res [25]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bis_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import bis_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

    // slot memory
    logic [ID_WIDTH-1:0] mem [CAPACITY];

    // control registers
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_vld, n_vld;
    logic          r_ovld, n_ovld;

    // payload registers
    logic [CW-1:0]       r_k, n_k;
    logic [AW-1:0]       r_vk, n_vk;
    t_op                 r_op, n_op;
    logic [ID_WIDTH-1:0] r_id, n_id;
    t_result             r_res, n_res;
    t_result             r_odata, n_odata;
    logic [ID_WIDTH-1:0] r_rd_data;

    // memory access controls
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [ID_WIDTH-1:0] wr_data;

    logic                hit;
    logic                out_free;
    logic [ID_WIDTH-1:0] in_id;
    logic [INDEX_W-1:0]  in_idx;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {(OUT_TDATA_W - RES_W)'(0), r_odata};

    assign in_id    = ID_WIDTH'(s_axis_tdata[ID_IN_W-1:0]);
    assign in_idx   = s_axis_tdata[ID_IN_W +: INDEX_W];
    assign hit      = r_vld && (r_rd_data == r_id);
    assign out_free = !r_ovld || m_axis_tready;

    // sequencer: next state, memory accesses and result
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_vld   = 1'b0;
        n_ovld  = r_ovld && !m_axis_tready;
        n_k     = r_k;
        n_vk    = r_vk;
        n_op    = r_op;
        n_id    = r_id;
        n_res   = r_res;
        n_odata = r_odata;
        rd_en   = 1'b0;
        rd_addr = r_k[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_vk - AW'(1);
        wr_data = r_rd_data;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op  = t_op'(s_axis_tuser);
                    n_id  = in_id;
                    n_k   = '0;
                    n_res = '{empty_res: (r_count == '0), size: SIZE_W'(r_count),
                              read_id: '0, found: 1'b0, status: 1'b0};
                    unique case (t_op'(s_axis_tuser))
                        OP_ADD: begin
                            if (in_id == '0 || r_count >= CW'(CAPACITY)) begin
                                n_res.status = 1'b1;
                                n_state      = ST_OUT;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_REMOVE: begin
                            if (in_id == '0) begin
                                n_res.status = 1'b1;
                                n_state      = ST_OUT;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_LOOKUP: begin
                            n_state = (in_id == '0) ? ST_OUT : ST_SCAN;
                        end
                        OP_READ: begin
                            if (XW'(in_idx) < XW'(r_count)) begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(in_idx);
                                n_state = ST_RDWAIT;
                            end else begin
                                n_state = ST_OUT;
                            end
                        end
                        default: n_state = ST_OUT;
                    endcase
                end
            end

            // one slot read per cycle, compared in the cycle after the read
            ST_SCAN: begin
                if (hit) begin
                    priority case (r_op)
                        OP_ADD: begin
                            n_res.status = 1'b1;
                            n_state      = ST_OUT;
                        end
                        OP_LOOKUP: begin
                            n_res.found = 1'b1;
                            n_state     = ST_OUT;
                        end
                        OP_REMOVE: begin
                            n_k     = CW'(r_vk) + CW'(1);
                            n_state = ST_SHIFT;
                        end
                        default: n_state = ST_OUT;
                    endcase
                end else if (!r_vld && r_k >= r_count) begin
                    priority case (r_op)
                        OP_ADD: begin
                            wr_en   = 1'b1;
                            wr_addr = r_count[AW-1:0];
                            wr_data = r_id;
                            n_count = r_count + CW'(1);
                            n_res.size      = SIZE_W'(r_count + CW'(1));
                            n_res.empty_res = 1'b0;
                        end
                        OP_REMOVE: n_res.status = 1'b1;
                        default:   n_res.found  = 1'b0;
                    endcase
                    n_state = ST_OUT;
                end else begin
                    rd_en = (r_k < r_count);
                    n_vld = rd_en;
                    n_vk  = r_k[AW-1:0];
                    if (rd_en) begin
                        n_k = r_k + CW'(1);
                    end
                end
            end

            // move later entries down: read slot k, write it to k - 1
            ST_SHIFT: begin
                if (r_vld) begin
                    wr_en = 1'b1;
                end
                if (!r_vld && r_k >= r_count) begin
                    n_count         = r_count - CW'(1);
                    n_res.size      = SIZE_W'(r_count - CW'(1));
                    n_res.empty_res = (r_count == CW'(1));
                    n_state         = ST_OUT;
                end else begin
                    rd_en = (r_k < r_count);
                    n_vld = rd_en;
                    n_vk  = r_k[AW-1:0];
                    if (rd_en) begin
                        n_k = r_k + CW'(1);
                    end
                end
            end

            ST_RDWAIT: begin
                n_res.read_id = ID_IN_W'(r_rd_data);
                n_state       = ST_OUT;
            end

            // hand the result to the output register once it is free
            ST_OUT: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_odata = r_res;
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_vld   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_vld   <= n_vld;
            r_ovld  <= n_ovld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_vk    <= n_vk;
        r_op    <= n_op;
        r_id    <= n_id;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

    // slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/bis_checker.sv
// ----------------------------------------------------------------------------
// bis_checker
// Port-level checks of the bounded identifier set unit, bound to the top.
// ----------------------------------------------------------------------------
module bis_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [bis_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [1:0]                      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bis_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import bis_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request at a time: ready drops after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while one is in progress");

    // an empty set reports size zero
    a_empty_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[25] |-> m_axis_tdata[24:18] == '0)
        else $error("empty flag with nonzero size");

    // found never comes with an error
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0])
        else $error("found reported together with error status");

endmodule

bind bounded_id_set_unit bis_checker u_bis_checker (.*);

### tb/sv/bounded_id_set_unit_test.sv
// ----------------------------------------------------------------------------
// bounded_id_set_unit_test
// Self-checking bench for the bounded identifier set unit. Requests go in
// on the stream input with random gaps, and results are taken with random
// back-pressure. Each accepted request is run through a local model of the
// set, and its result is queued and compared field by field with what
// comes out. Directed cases come first, then a fill to capacity and a full
// drain, then random mixes tuned to grow, shrink and churn the set.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bounded_id_set_unit_test;
    import bis_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int MAX_GAP      = 18;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int REPORT_LIMIT = 10;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // id [15:0], index [21:16], zero padding [23:22]
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // operation [1:0]
    logic [1:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // status [0], found [1], read_id [17:2], size [24:18], empty_res [25]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // local copy of the set contents
    logic [ID_IN_W-1:0] held_ids [CAPACITY];
    int                 held_count;

    t_result pending_results [$];
    int      mismatch_count = 0;
    bit      src_burst      = 1'b0;
    bit      snk_burst      = 1'b0;

    bounded_id_set_unit #(
        .CAPACITY (CAPACITY),
        .ID_WIDTH (ID_IN_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // slot of a held identifier, or -1
    function automatic int find_held(logic [ID_IN_W-1:0] id);
        for (int k = 0; k < held_count; k++) begin
            if (held_ids[k] == id) return k;
        end
        return -1;
    endfunction

    // apply one request to the local set and give its result
    function automatic t_result apply_request(t_op op, logic [ID_IN_W-1:0] id,
                                              logic [INDEX_W-1:0] idx);
        t_result res;
        int      pos;
        res = '0;
        case (op)
            OP_ADD: begin
                if (id == '0 || find_held(id) >= 0 || held_count >= CAPACITY) begin
                    res.status = 1'b1;
                end else begin
                    held_ids[held_count] = id;
                    held_count++;
                end
            end
            OP_REMOVE: begin
                pos = (id == '0) ? -1 : find_held(id);
                if (pos < 0) begin
                    res.status = 1'b1;
                end else begin
                    // close the gap and clear the freed slot
                    for (int k = pos; k + 1 < held_count; k++) begin
                        held_ids[k] = held_ids[k + 1];
                    end
                    held_ids[held_count - 1] = '0;
                    held_count--;
                end
            end
            OP_LOOKUP: begin
                res.found = (id != '0) && (find_held(id) >= 0);
            end
            OP_READ: begin
                if (idx < held_count) res.read_id = held_ids[idx];
            end
        endcase
        res.size      = SIZE_W'(held_count);
        res.empty_res = (held_count == 0);
        return res;
    endfunction

    function automatic void report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("mismatch at %0t: %s", $time, what);
    endfunction

    // send one request after a random gap, predict on acceptance
    task automatic send_request(t_op op, logic [ID_IN_W-1:0] id,
                                logic [INDEX_W-1:0] idx);
        int gap;
        if ($urandom_range(0, 31) == 0) src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) @(negedge i_clk) s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, idx, id};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_request(op, id, idx));
    endtask

    // hold off the source until every pending result is out
    task automatic wait_for_results();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // many identifiers that hit, some misses, the odd zero
    function automatic logic [ID_IN_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return '0;
        if (r < 45 && held_count > 0) return held_ids[$urandom_range(0, held_count - 1)];
        if (r < 75) return ID_IN_W'($urandom_range(1, 96));
        return ID_IN_W'($urandom_range(1, 65535));
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index();
        if (held_count > 0 && $urandom_range(0, 3) != 0)
            return INDEX_W'($urandom_range(0, held_count - 1));
        return INDEX_W'($urandom_range(0, CAPACITY - 1));
    endfunction

    // edge cases on an empty and a small set
    task automatic test_directed();
        send_request(OP_READ,   16'h0000, 6'd0);
        send_request(OP_LOOKUP, 16'h0000, 6'd0);
        send_request(OP_ADD,    16'h0000, 6'd0);
        send_request(OP_REMOVE, 16'h0000, 6'd0);
        send_request(OP_REMOVE, 16'h1234, 6'd0);
        send_request(OP_ADD,    16'h0001, 6'h3f);
        send_request(OP_ADD,    16'hffff, 6'd0);
        send_request(OP_ADD,    16'h0001, 6'd0);
        send_request(OP_ADD,    16'h5aa5, 6'd0);
        send_request(OP_LOOKUP, 16'hffff, 6'h3f);
        send_request(OP_LOOKUP, 16'h0002, 6'd0);
        send_request(OP_LOOKUP, 16'h0000, 6'd0);
        send_request(OP_READ,   16'h0000, 6'd0);
        send_request(OP_READ,   16'hffff, 6'd1);
        send_request(OP_READ,   16'h0000, 6'd2);
        send_request(OP_READ,   16'h0000, 6'd3);
        send_request(OP_READ,   16'h0000, 6'h3f);
        send_request(OP_REMOVE, 16'h0001, 6'd0);
        send_request(OP_READ,   16'h0000, 6'd0);
        send_request(OP_READ,   16'h0000, 6'd2);
        send_request(OP_REMOVE, 16'h0001, 6'd0);
        send_request(OP_REMOVE, 16'h5aa5, 6'd0);
        send_request(OP_REMOVE, 16'hffff, 6'd0);
        send_request(OP_READ,   16'h0000, 6'd0);
    endtask

    // fill to capacity, poke the full set, then empty it in random order
    task automatic test_fill_and_drain();
        logic [ID_IN_W-1:0] id;
        int                 pos;
        while (held_count < CAPACITY) begin
            do id = ID_IN_W'($urandom_range(1, 65535)); while (find_held(id) >= 0);
            send_request(OP_ADD, id, INDEX_W'($urandom_range(0, CAPACITY - 1)));
        end
        send_request(OP_ADD, held_ids[10], 6'd0);
        do id = ID_IN_W'($urandom_range(1, 65535)); while (find_held(id) >= 0);
        send_request(OP_ADD, id, 6'd0);
        send_request(OP_ADD, 16'h0000, 6'd0);
        send_request(OP_READ, 16'h0000, 6'h3f);
        send_request(OP_LOOKUP, held_ids[CAPACITY - 1], 6'd0);
        // longest shift: head of a full set
        send_request(OP_REMOVE, held_ids[0], 6'd0);
        send_request(OP_READ, 16'h0000, 6'h3f);
        send_request(OP_READ, 16'h0000, 6'h3e);
        do id = ID_IN_W'($urandom_range(1, 65535)); while (find_held(id) >= 0);
        send_request(OP_ADD, id, 6'd0);
        send_request(OP_REMOVE, held_ids[CAPACITY - 1], 6'd0);
        while (held_count > 0) begin
            pos = $urandom_range(0, held_count - 1);
            send_request(OP_REMOVE, held_ids[pos], 6'd0);
            if ($urandom_range(0, 3) == 0)
                send_request(OP_READ, pick_id(), INDEX_W'($urandom_range(0, CAPACITY - 1)));
        end
    endtask

    // random mix, weighted towards growing or shrinking the set
    task automatic test_random_mix(int items, int add_pct, int remove_pct);
        int  r;
        t_op op;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct)
                op = OP_ADD;
            else if (r < add_pct + remove_pct)
                op = OP_REMOVE;
            else if (r < add_pct + remove_pct + (100 - add_pct - remove_pct) / 2)
                op = OP_LOOKUP;
            else
                op = OP_READ;
            send_request(op, pick_id(), pick_index());
        end
    endtask

    // result sink with random stalls
    initial begin : result_sink
        int stall;
        wait (i_rst_n);
        forever begin
            if ($urandom_range(0, 31) == 0) snk_burst = !snk_burst;
            stall = snk_burst ? 0 : $urandom_range(0, MAX_GAP);
            repeat (stall) @(negedge i_clk) m_axis_tready <= 1'b0;
            @(negedge i_clk) m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[RES_W-1:0]);
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing pending", got));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.found !== want.found ||
                    got.read_id !== want.read_id || got.size !== want.size ||
                    got.empty_res !== want.empty_res) begin
                    report_mismatch($sformatf(
                        "exp/got status %0b/%0b found %0b/%0b read_id %h/%h size %0d/%0d empty %0b/%0b",
                        want.status, got.status, want.found, got.found,
                        want.read_id, got.read_id, want.size, got.size,
                        want.empty_res, got.empty_res));
                end
            end
        end
    end

    // watchdog
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("bounded_id_set_unit_test failed");
        $finish;
    end

    // test sequence
    initial begin : run_tests
        held_count = 0;
        foreach (held_ids[k]) held_ids[k] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        wait_for_results();
        test_fill_and_drain();
        wait_for_results();
        test_random_mix(250, 55, 15);
        test_random_mix(200, 20, 50);
        wait_for_results();
        test_random_mix(220, 35, 35);
        wait_for_results();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("bounded_id_set_unit_test passed");
        end else begin
            $display("bounded_id_set_unit_test failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/bis_pkg.sv
rtl/bounded_id_set_unit.sv
rtl/bis_checker.sv
tb/sv/bounded_id_set_unit_test.sv
